// ===== src/stup_pkg.sv =====
// Shared types, widths and character helpers for the string-to-unsigned parser.
// No dependencies; imported by every module of the block.
package stup_pkg;

  localparam int VALUE_BITS_DEF    = 64;
  localparam int POSITION_BITS_DEF = 12;
  localparam int CHAR_W            = 8;
  localparam int RADIX_W           = 6;
  localparam int OFFSET_W          = 12;
  localparam int DIGIT_W           = 7;

  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd99;
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;

  typedef struct packed {
    logic                overflowed;
    logic                no_digits;
    logic [OFFSET_W-1:0] end_offset;
  } res_flags_t;

  // Digit value of a character, NOT_DIGIT when it is neither 0-9 nor a letter.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = 8'd0;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
    end else if (c >= "a" && c <= "z") begin
      t = c - 8'h61 + 8'd10;
    end else if (c >= "A" && c <= "Z") begin
      t = c - 8'h41 + 8'd10;
    end else begin
      t = {1'b0, NOT_DIGIT};
    end
    return t[DIGIT_W-1:0];
  endfunction

  // Space, TAB, LF, VT, FF, CR.
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== src/stup_in_reg.sv =====
// Input register stage: one request per cycle unless stalled, held for the core.
// Depends on stup_pkg.
module stup_in_reg
  import stup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic              in_first,
  output logic              in_stall,
  output logic              a_valid,
  output logic [CHAR_W-1:0] a_ch,
  output logic              a_first,
  input  logic              a_take
);

  logic              valid_r;
  logic [CHAR_W-1:0] ch_r;
  logic              first_r;

  // Slot is free when empty or being drained this cycle.
  assign in_stall = valid_r && !a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r    <= in_ch;
      first_r <= in_first;
    end
  end

  assign a_valid = valid_r;
  assign a_ch    = ch_r;
  assign a_first = first_r;

endmodule

// ===== src/stup_core.sv =====
// Parse state and one-character step logic, including the radix register.
// Depends on stup_pkg.
module stup_core
  import stup_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data,
  input  logic                  a_valid,
  input  logic [CHAR_W-1:0]     a_ch,
  input  logic                  a_first,
  input  logic                  out_free,
  output logic                  a_take,
  output logic                  res_load,
  output logic [VALUE_BITS-1:0] res_value,
  output res_flags_t            res_flags
);

  localparam int PW = VALUE_BITS + RADIX_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  phase_t                   phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     minus_r, minus_nxt;
  logic                     dseen_r, dseen_nxt;
  logic [RADIX_W-1:0]       base_r, base_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [RADIX_W-1:0]       radix_r;
  logic                     produces;

  always_comb begin : step_logic
    logic                  stop;
    logic                  adv;
    logic [DIGIT_W-1:0]    d;
    logic [PW-1:0]         prod;

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    minus_nxt = minus_r;
    dseen_nxt = dseen_r;
    base_nxt  = base_r;
    pos_nxt   = pos_r;
    stop      = 1'b0;
    adv       = 1'b0;
    produces  = 1'b0;
    d         = digit_of(a_ch);
    prod      = '0;

    if (a_first) begin
      phase_nxt = PH_SPACE;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      minus_nxt = 1'b0;
      dseen_nxt = 1'b0;
      base_nxt  = '0;
      pos_nxt   = '0;
    end else if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
      stop = 1'b1;
    end

    // Phases fall through within one character, as far as it takes them.
    if (!stop && phase_nxt == PH_SPACE) begin
      if (is_space(a_ch)) begin
        adv  = 1'b1;
        stop = 1'b1;
      end else if (a_ch == "-" || a_ch == "+") begin
        minus_nxt = (a_ch == "-");
        phase_nxt = PH_START;
        adv       = 1'b1;
        stop      = 1'b1;
      end else begin
        phase_nxt = PH_START;
      end
    end

    if (!stop && phase_nxt == PH_START) begin
      base_nxt = radix_r;
      if ((radix_r == RADIX_AUTO || radix_r == BASE_HEX) && a_ch == "0") begin
        base_nxt  = (radix_r == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
        phase_nxt = PH_ZERO;
        adv       = 1'b1;
        stop      = 1'b1;
      end else begin
        if (radix_r == RADIX_AUTO) begin
          base_nxt = BASE_DEC;
        end
        phase_nxt = PH_DIGITS;
      end
    end

    if (!stop && phase_nxt == PH_ZERO) begin
      if (a_ch == "x" || a_ch == "X") begin
        base_nxt  = BASE_HEX;
        phase_nxt = PH_DIGITS;
        adv       = 1'b1;
        stop      = 1'b1;
      end else begin
        dseen_nxt = 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end

    if (!stop) begin
      if (base_nxt < BASE_MIN || base_nxt > BASE_MAX ||
          {1'b0, d} >= {{(DIGIT_W + 1 - RADIX_W){1'b0}}, base_nxt}) begin
        produces  = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        // Widened multiply-add: any bit above the value width is overflow.
        prod = PW'(acc_nxt) * PW'(base_nxt) + PW'(d);
        if (prod[PW-1:VALUE_BITS] != '0) begin
          ovf_nxt = 1'b1;
        end
        acc_nxt   = prod[VALUE_BITS-1:0];
        dseen_nxt = 1'b1;
        adv       = 1'b1;
      end
    end

    if (adv && pos_nxt != POS_MAX) begin
      pos_nxt = pos_nxt + POSITION_BITS'(1);
    end
  end

  assign a_take   = a_valid && (!produces || out_free);
  assign res_load = a_take && produces;

  always_comb begin
    if (!dseen_nxt) begin
      res_value            = '0;
      res_flags.overflowed = 1'b0;
      res_flags.no_digits  = 1'b1;
      res_flags.end_offset = '0;
    end else begin
      if (ovf_nxt) begin
        res_value = {VALUE_BITS{1'b1}};
      end else if (minus_nxt) begin
        res_value = {VALUE_BITS{1'b0}} - acc_nxt;
      end else begin
        res_value = acc_nxt;
      end
      res_flags.overflowed = ovf_nxt;
      res_flags.no_digits  = 1'b0;
      res_flags.end_offset = OFFSET_W'(pos_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      minus_r <= 1'b0;
      dseen_r <= 1'b0;
      base_r  <= '0;
      pos_r   <= '0;
      radix_r <= RADIX_AUTO;
    end else begin
      if (a_take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        minus_r <= minus_nxt;
        dseen_r <= dseen_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
      end
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== src/stup_out_reg.sv =====
// Result register: holds one finished request until the consumer takes it.
// Depends on stup_pkg.
module stup_out_reg
  import stup_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_load,
  input  logic [VALUE_BITS-1:0] res_value,
  input  res_flags_t            res_flags,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_value,
  output res_flags_t            out_flags
);

  logic                  valid_r;
  logic [VALUE_BITS-1:0] value_r;
  res_flags_t            flags_r;

  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_r <= res_value;
      flags_r <= res_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_flags = flags_r;

endmodule

// ===== src/string_to_unsigned_parser.sv =====
// Streaming ASCII to unsigned integer parser, one character per request.
// Throughput: one character per cycle unless stalled (combinational multiply-add).
// Path: a terminating character is captured in the input register, and its result
//   is loaded into the result register once that register is free.
// Reset (rst_n low, synchronous): parser idle, radix = 0 (auto), both registers empty.
// Depends on stup_pkg, stup_in_reg, stup_core, stup_out_reg.
module string_to_unsigned_parser
  import stup_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // radix register write
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_wr_data,
  // character requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_ch,
  input  logic                  in_first,
  // result requests
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_value,
  output logic                  out_overflowed,
  output logic                  out_no_digits,
  output logic [OFFSET_W-1:0]   out_end_offset
);

  logic                  a_valid;
  logic [CHAR_W-1:0]     a_ch;
  logic                  a_first;
  logic                  a_take;
  logic                  out_free;
  logic                  res_load;
  logic [VALUE_BITS-1:0] res_value;
  res_flags_t            res_flags;
  res_flags_t            out_flags;

  // Input register: decouples upstream from the step logic.
  stup_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_first (in_first),
    .in_stall (in_stall),
    .a_valid  (a_valid),
    .a_ch     (a_ch),
    .a_first  (a_first),
    .a_take   (a_take)
  );

  // Step logic. A character that ends the parse waits in the input register
  // only while the result register is full and stalled; all other
  // characters go straight through and keep the stream moving.
  stup_core #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .a_valid     (a_valid),
    .a_ch        (a_ch),
    .a_first     (a_first),
    .out_free    (out_free),
    .a_take      (a_take),
    .res_load    (res_load),
    .res_value   (res_value),
    .res_flags   (res_flags)
  );

  // Result register: the only place a finished result waits.
  stup_out_reg #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_value (res_value),
    .res_flags (res_flags),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_flags (out_flags)
  );

  assign out_overflowed = out_flags.overflowed;
  assign out_no_digits  = out_flags.no_digits;
  assign out_end_offset = out_flags.end_offset;

endmodule
